/* rtl/first_fit_heap_allocator_assert.svh */
// Assertion macros used by the allocator datapath.
`ifndef FIRST_FIT_HEAP_ALLOCATOR_ASSERT_SVH
`define FIRST_FIT_HEAP_ALLOCATOR_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define FFHA_ASSERT_NOW(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("allocator assertion failed");

// Next-cycle implication, checked outside reset.
`define FFHA_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("allocator assertion failed");

`endif

/* rtl/ffha_pkg.sv */
// ----------------------------------------------------------------------------
// ffha_pkg
// Types and constants of the first-fit heap allocator.
// ----------------------------------------------------------------------------
package ffha_pkg;

   localparam int HEAP_BYTES   = 4096;
   localparam int HEADER_BYTES = 16;
   localparam int MAX_BLOCKS   = 64;

   localparam int OFF_W = 12;
   localparam int SIZE_W = 13;
   localparam int IDX_W = $clog2(MAX_BLOCKS);
   localparam int CNT_W = $clog2(MAX_BLOCKS + 1);

   localparam logic ACT_ALLOC = 1'b0;
   localparam logic ACT_FREE  = 1'b1;

   typedef enum logic [1:0] {
      ST_DONE    = 2'd0,
      ST_NOFIT   = 2'd1,
      ST_FULL    = 2'd2,
      ST_BADFREE = 2'd3
   } status_type;

   typedef struct packed {
      logic              action;
      logic [SIZE_W-1:0] request_bytes;
      logic [OFF_W-1:0]  payload_offset;
   } req_type;

   typedef struct packed {
      status_type       status;
      logic [OFF_W-1:0] granted_offset;
   } rsp_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_SEARCH,
      S_EXEC,
      S_MERGE_NEXT,
      S_MERGE_PREV,
      S_DONE
   } state_type;

   typedef enum logic [2:0] {
      DP_NONE,
      DP_CAPTURE,
      DP_SEARCH,
      DP_EXEC,
      DP_MERGE_NEXT,
      DP_MERGE_PREV
   } dp_op_type;

   typedef struct packed {
      dp_op_type op;
      logic      load_rsp;
   } dp_cmd_type;

   typedef struct packed {
      logic is_free;
      logic found;
      logic rsp_busy;
   } dp_stat_type;

endpackage

/* rtl/first_fit_heap_allocator.sv */
// ----------------------------------------------------------------------------
// first_fit_heap_allocator
// First-fit heap allocator with block splitting and free-block coalescing.
// ----------------------------------------------------------------------------
// Usage:
//   Request channel req_valid/req_stall/req_data carries one beat per
//   operation: action 0 allocates request_bytes, action 1 frees the block
//   whose payload starts at payload_offset.
//   Response channel rsp_valid/rsp_stall/rsp_data returns one beat per
//   request: a status and, for a successful allocate, the payload offset.
//   Sequence: the block table is searched by all cells in parallel, then
//   the allocate (with any split shift) or the release is applied. A free
//   that releases a block then merges with the next and then with the
//   previous block; one operation is in flight at a time.
//   The result sits in an output register; a new request is taken while it
//   waits, and the following result waits until rsp_stall drops.
//   Reset (synchronous, active high) leaves one free block spanning the
//   heap and no response pending.
// ----------------------------------------------------------------------------
module first_fit_heap_allocator
   import ffha_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   dp_cmd_type  cmd;
   dp_stat_type stat;

   ffha_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .stat      (stat),
      .cmd       (cmd)
   );

   ffha_datapath u_datapath (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .cmd       (cmd),
      .stat      (stat),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule

/* rtl/ffha_ctrl.sv */
// ----------------------------------------------------------------------------
// ffha_ctrl
// Sequencer: capture, search, execute, optional merges, result handoff.
// ----------------------------------------------------------------------------
module ffha_ctrl
   import ffha_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  dp_stat_type stat,
   output dp_cmd_type  cmd
);

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) state_in = S_SEARCH;
         end
         S_SEARCH: state_in = S_EXEC;
         S_EXEC: begin
            if (stat.is_free && stat.found) state_in = S_MERGE_NEXT;
            else state_in = S_DONE;
         end
         S_MERGE_NEXT: state_in = S_MERGE_PREV;
         S_MERGE_PREV: state_in = S_DONE;
         S_DONE: begin
            if (!stat.rsp_busy) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_comb begin
      cmd.op = DP_NONE;
      cmd.load_rsp = 1'b0;
      req_stall = 1'b1;
      unique case (state_ff)
         S_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) cmd.op = DP_CAPTURE;
         end
         S_SEARCH:     cmd.op = DP_SEARCH;
         S_EXEC:       cmd.op = DP_EXEC;
         S_MERGE_NEXT: cmd.op = DP_MERGE_NEXT;
         S_MERGE_PREV: cmd.op = DP_MERGE_PREV;
         S_DONE:       cmd.load_rsp = !stat.rsp_busy;
         default:      cmd.op = DP_NONE;
      endcase
   end

endmodule

/* rtl/ffha_datapath.sv */
// ----------------------------------------------------------------------------
// ffha_datapath
// Block table cells, parallel search, split/merge shifts, result register.
// ----------------------------------------------------------------------------
`include "first_fit_heap_allocator_assert.svh"

module ffha_datapath
   import ffha_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  req_type     req_data,
   input  dp_cmd_type  cmd,
   output dp_stat_type stat,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output rsp_type     rsp_data
);

   localparam logic [SIZE_W-1:0] HDR_SZ = SIZE_W'(HEADER_BYTES);

   logic [OFF_W-1:0]  start_ff   [MAX_BLOCKS];
   logic [OFF_W-1:0]  start_in   [MAX_BLOCKS];
   logic [SIZE_W-1:0] payload_ff [MAX_BLOCKS];
   logic [SIZE_W-1:0] payload_in [MAX_BLOCKS];
   logic [MAX_BLOCKS-1:0] used_ff, used_in;
   logic [CNT_W-1:0]  count_ff, count_in;

   req_type           cap_ff, cap_in;
   logic              found_ff, found_in;
   logic [IDX_W-1:0]  idx_ff, idx_in;
   rsp_type           res_ff, res_in;
   logic              rsp_valid_ff, rsp_valid_in;
   rsp_type           rsp_ff, rsp_in;

   logic [MAX_BLOCKS-1:0] hit;
   logic              any_hit;
   logic [IDX_W-1:0]  first_idx;
   logic [OFF_W-1:0]  sel_start;
   logic [SIZE_W-1:0] sel_payload;
   logic [SIZE_W-1:0] diff;
   logic              split;
   logic [SIZE_W:0]   new_start_w;
   logic              next_ok, prev_ok;

   assign sel_start   = start_ff[idx_ff];
   assign sel_payload = payload_ff[idx_ff];
   assign diff        = sel_payload - cap_ff.request_bytes;
   assign split       = diff > HDR_SZ;
   assign new_start_w = {2'b00, sel_start} + {1'b0, HDR_SZ} + {1'b0, cap_ff.request_bytes};

   // Per-cell match, then lowest matching index wins.
   always_comb begin
      hit = '0;
      for (int j = 0; j < MAX_BLOCKS; j++) begin
         if (CNT_W'(j) < count_ff) begin
            if (cap_ff.action == ACT_ALLOC)
               hit[j] = !used_ff[j] && (payload_ff[j] >= cap_ff.request_bytes);
            else
               hit[j] = used_ff[j] &&
                  (({1'b0, start_ff[j]} + HDR_SZ) == {1'b0, cap_ff.payload_offset});
         end
      end
      any_hit = |hit;
      first_idx = '0;
      for (int j = MAX_BLOCKS - 1; j >= 0; j--) begin
         if (hit[j]) first_idx = IDX_W'(j);
      end
   end

   always_comb begin
      next_ok = 1'b0;
      prev_ok = 1'b0;
      for (int j = 0; j < MAX_BLOCKS - 1; j++) begin
         if (IDX_W'(j) == idx_ff && CNT_W'(j + 1) < count_ff && !used_ff[j + 1])
            next_ok = 1'b1;
      end
      for (int j = 1; j < MAX_BLOCKS; j++) begin
         if (IDX_W'(j) == idx_ff && !used_ff[j - 1]) prev_ok = 1'b1;
      end
   end

   always_comb begin
      start_in   = start_ff;
      payload_in = payload_ff;
      used_in    = used_ff;
      count_in   = count_ff;
      cap_in     = cap_ff;
      found_in   = found_ff;
      idx_in     = idx_ff;
      res_in     = res_ff;
      unique case (cmd.op)
         DP_CAPTURE: cap_in = req_data;
         DP_SEARCH: begin
            found_in = any_hit;
            idx_in   = first_idx;
         end
         DP_EXEC: begin
            res_in.granted_offset = '0;
            if (cap_ff.action == ACT_ALLOC) begin
               if (!found_ff) begin
                  res_in.status = ST_NOFIT;
               end else if (split && count_ff >= CNT_W'(MAX_BLOCKS)) begin
                  res_in.status = ST_FULL;
               end else begin
                  res_in.status = ST_DONE;
                  res_in.granted_offset = sel_start + OFF_W'(HEADER_BYTES);
                  used_in[idx_ff] = 1'b1;
                  if (split) begin
                     payload_in[idx_ff] = cap_ff.request_bytes;
                     count_in = count_ff + 1'b1;
                     for (int j = 1; j < MAX_BLOCKS; j++) begin
                        if (IDX_W'(j - 1) == idx_ff) begin
                           start_in[j]   = new_start_w[OFF_W-1:0];
                           payload_in[j] = diff - HDR_SZ;
                           used_in[j]    = 1'b0;
                        end else if (IDX_W'(j) > idx_ff) begin
                           start_in[j]   = start_ff[j - 1];
                           payload_in[j] = payload_ff[j - 1];
                           used_in[j]    = used_ff[j - 1];
                        end
                     end
                  end
               end
            end else begin
               if (!found_ff) begin
                  res_in.status = ST_BADFREE;
               end else begin
                  res_in.status = ST_DONE;
                  used_in[idx_ff] = 1'b0;
               end
            end
         end
         DP_MERGE_NEXT: begin
            if (next_ok) begin
               count_in = count_ff - 1'b1;
               for (int j = 0; j < MAX_BLOCKS - 1; j++) begin
                  if (IDX_W'(j) == idx_ff) begin
                     payload_in[j] = payload_ff[j] + HDR_SZ + payload_ff[j + 1];
                  end else if (IDX_W'(j) > idx_ff) begin
                     start_in[j]   = start_ff[j + 1];
                     payload_in[j] = payload_ff[j + 1];
                     used_in[j]    = used_ff[j + 1];
                  end
               end
            end
         end
         DP_MERGE_PREV: begin
            if (prev_ok) begin
               count_in = count_ff - 1'b1;
               for (int j = 0; j < MAX_BLOCKS - 1; j++) begin
                  if (IDX_W'(j + 1) == idx_ff) begin
                     payload_in[j] = payload_ff[j] + HDR_SZ + payload_ff[j + 1];
                  end else if (IDX_W'(j) >= idx_ff) begin
                     start_in[j]   = start_ff[j + 1];
                     payload_in[j] = payload_ff[j + 1];
                     used_in[j]    = used_ff[j + 1];
                  end
               end
            end
         end
         default: ;
      endcase
   end

   // Output beat register; a new result may load while the old one drains.
   always_comb begin
      rsp_in = rsp_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      if (cmd.load_rsp) begin
         rsp_in = res_ff;
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      cap_ff     <= cap_in;
      found_ff   <= found_in;
      idx_ff     <= idx_in;
      res_ff     <= res_in;
      rsp_ff     <= rsp_in;
      if (reset) begin
         start_ff[0]   <= '0;
         payload_ff[0] <= SIZE_W'(HEAP_BYTES - HEADER_BYTES);
         used_ff       <= '0;
         count_ff      <= CNT_W'(1);
         rsp_valid_ff  <= 1'b0;
      end else begin
         start_ff     <= start_in;
         payload_ff   <= payload_in;
         used_ff      <= used_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign stat.is_free  = cap_ff.action == ACT_FREE;
   assign stat.found    = found_ff;
   assign stat.rsp_busy = rsp_valid_ff && rsp_stall;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   `FFHA_ASSERT_NOW(a_count_range, 1'b1, count_ff != '0 && count_ff <= CNT_W'(MAX_BLOCKS))
   `FFHA_ASSERT_NEXT(a_load_valid, cmd.load_rsp, rsp_valid_ff)
   `FFHA_ASSERT_NOW(a_offset_zero, rsp_valid_ff && rsp_ff.status != ST_DONE, rsp_ff.granted_offset == '0)
   `FFHA_ASSERT_NOW(a_first_free, cmd.op == DP_MERGE_PREV, !used_ff[0] || idx_ff != '0 || count_ff != '0)

endmodule
